@@ hdl/trhf_pkg.sv @@
// shared types and constants for the tangent range and height finder
`timescale 1ns / 1ps

package trhf_pkg;

   // input angle, configuration, output and internal widths
   localparam int ANGLE_W  = 17;
   localparam int HEIGHT_W = 23;
   localparam int DEPTH_W  = 5;
   localparam int OUT_W    = 48;
   localparam int TAN_W    = 39;
   localparam int DIV_W    = 64;

   // largest accepted angle, 1.4 rad in Q1.16
   localparam logic [ANGLE_W-1:0] ANGLE_MAX = 17'd91750;
   // 1.0 in Q.30
   localparam logic [DIV_W-1:0] Q30_ONE = 64'd1 << 30;
   // saturation values
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
   localparam logic [TAN_W-1:0] TAN_SAT = {TAN_W{1'b1}};

   // register addresses on the csr port
   localparam logic REG_INSTR_HEIGHT = 1'b0;
   localparam logic REG_FRAC_DEPTH   = 1'b1;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_TAN_INIT,
      OP_TERM_DIV,
      OP_TERM_END,
      OP_TAN_SAT,
      OP_FINAL_DIV,
      OP_FINAL_END,
      OP_DIST_DIV,
      OP_DIST_SAT,
      OP_DIST_END,
      OP_SEL_BETA,
      OP_MUL_START,
      OP_HEIGHT_END
   } trhf_op_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic k_zero;
      logic f_ge_base;
      logic f_ge_one;
      logic t_zero;
      logic want_h;
      logic bad;
      logic beta_sel;
   } trhf_stat_type;

endpackage

@@ hdl/trhf_div.sv @@
// restoring radix-2 divider, one quotient bit per cycle
`timescale 1ns / 1ps

module trhf_div
   import trhf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic [DIV_W-1:0] quo,
   output logic             done
);

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;

   // operand load on start, else one shift and subtract step
   always_comb begin
      trial   = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = CW'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

@@ hdl/trhf_dp.sv @@
// datapath: angle registers, continued fraction, distance and height
`timescale 1ns / 1ps

module trhf_dp
   import trhf_pkg::*;
#(
   parameter int MAX_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  trhf_op_type         op,
   input  logic [ANGLE_W-1:0]  alpha_in,
   input  logic [ANGLE_W-1:0]  beta_in,
   input  logic [HEIGHT_W-1:0] h,
   input  logic [DEPTH_W-1:0]  depth,
   output trhf_stat_type       stat,
   output logic [OUT_W-1:0]    distance,
   output logic [OUT_W-1:0]    object_height,
   output logic                height_valid,
   output logic                status
);

   localparam int KW = $clog2(MAX_DEPTH + 1);
   localparam int MW = OUT_W + TAN_W + 1;
   localparam int MCW = $clog2(TAN_W + 1);

   logic [ANGLE_W-1:0] alpha_ff, beta_ff;
   logic [2*ANGLE_W-1:0] x2_ff;
   logic [DIV_W-1:0]   f_ff;
   logic [KW-1:0]      k_ff;
   logic [TAN_W-1:0]   t_ff;
   logic [OUT_W-1:0]   dist_ff, hgt_ff;
   logic               hval_ff, bad_ff, sel_ff;
   logic [MW-1:0]      acc_ff;
   logic [MCW-1:0]     mcnt_ff;
   logic               mbusy_ff, mdone_ff;

   logic [ANGLE_W-1:0] cur_a;
   logic [DIV_W-1:0]   base;
   logic [KW-1:0]      k_start;
   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_num, div_den, div_q;
   logic [MW-33:0]     prod_hi;
   logic [OUT_W-1:0]   prod_sat;
   logic [OUT_W:0]     hsum;
   logic               bad_now;

   assign cur_a = sel_ff ? beta_ff : alpha_ff;
   assign base  = DIV_W'({k_ff, 1'b1}) << 30;

   // effective depth, zero acts as one and large values clamp
   always_comb begin
      if (depth == '0) begin
         k_start = KW'(1);
      end else if ({1'b0, depth} > (DEPTH_W+1)'(MAX_DEPTH)) begin
         k_start = KW'(MAX_DEPTH);
      end else begin
         k_start = KW'(depth);
      end
   end

   // range check of the incoming angles
   assign bad_now = (alpha_in == '0) || (alpha_in > ANGLE_MAX) ||
                    ((beta_in != '0) && (beta_in > ANGLE_MAX));

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (op)
         OP_TERM_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(x2_ff) << 28;
            div_den   = base - f_ff;
         end
         OP_FINAL_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(cur_a) << 46;
            div_den   = Q30_ONE - f_ff;
         end
         OP_DIST_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(h) << 32;
            div_den   = DIV_W'(t_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   trhf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_q),
      .done  (div_done)
   );

   // height from the product, saturated twice
   always_comb begin
      prod_hi  = acc_ff[MW-1:32];
      prod_sat = (prod_hi > (MW-32)'(OUT_MAX)) ? OUT_MAX : prod_hi[OUT_W-1:0];
      hsum     = {1'b0, prod_sat} + (OUT_W+1)'(h);
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         if (op == OP_MUL_START) begin
            mbusy_ff <= 1'b1;
            mdone_ff <= 1'b0;
         end else if (mbusy_ff && mcnt_ff == '0) begin
            mbusy_ff <= 1'b0;
            mdone_ff <= 1'b1;
         end else begin
            mdone_ff <= 1'b0;
         end
         if (op == OP_LOAD) begin
            sel_ff <= 1'b0;
         end else if (op == OP_SEL_BETA) begin
            sel_ff <= 1'b1;
         end
      end
      // serial multiply, tangent bits from the top
      if (op == OP_MUL_START) begin
         acc_ff  <= '0;
         mcnt_ff <= MCW'(TAN_W - 1);
      end else if (mbusy_ff) begin
         acc_ff  <= (acc_ff << 1) + (t_ff[mcnt_ff[$clog2(TAN_W)-1:0]] ?
                    MW'(dist_ff) : '0);
         mcnt_ff <= mcnt_ff - 1'b1;
      end
      case (op)
         OP_LOAD: begin
            alpha_ff <= alpha_in;
            beta_ff  <= beta_in;
            bad_ff   <= bad_now;
            dist_ff  <= '0;
            hgt_ff   <= '0;
            hval_ff  <= 1'b0;
         end
         OP_TAN_INIT: begin
            x2_ff <= cur_a * cur_a;
            f_ff  <= Q30_ONE;
            k_ff  <= k_start;
         end
         OP_TERM_END: begin
            f_ff <= div_q;
            k_ff <= k_ff - 1'b1;
         end
         OP_TAN_SAT: begin
            t_ff <= TAN_SAT;
         end
         OP_FINAL_END: begin
            t_ff <= (div_q > DIV_W'(TAN_SAT)) ? TAN_SAT : div_q[TAN_W-1:0];
         end
         OP_DIST_SAT: begin
            dist_ff <= OUT_MAX;
         end
         OP_DIST_END: begin
            dist_ff <= (div_q > DIV_W'(OUT_MAX)) ? OUT_MAX : div_q[OUT_W-1:0];
         end
         OP_HEIGHT_END: begin
            hgt_ff  <= hsum[OUT_W] ? OUT_MAX : hsum[OUT_W-1:0];
            hval_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign stat.div_done  = div_done;
   assign stat.mul_done  = mdone_ff;
   assign stat.k_zero    = (k_ff == '0);
   assign stat.f_ge_base = (f_ff >= base);
   assign stat.f_ge_one  = (f_ff >= Q30_ONE);
   assign stat.t_zero    = (t_ff == '0);
   assign stat.want_h    = (beta_ff != '0);
   assign stat.bad       = bad_ff;
   assign stat.beta_sel  = sel_ff;

   assign distance      = dist_ff;
   assign object_height = hgt_ff;
   assign height_valid  = hval_ff;
   assign status        = bad_ff;

endmodule

@@ hdl/trhf_ctrl.sv @@
// controller: sequences the tangent, distance and height steps
`timescale 1ns / 1ps

module trhf_ctrl
   import trhf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  logic          out_free,
   input  trhf_stat_type stat,
   output trhf_op_type   op,
   output logic          ready,
   output logic          out_load
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_TERM,
      S_TERM_WAIT,
      S_FINAL,
      S_FINAL_WAIT,
      S_TAN_DONE,
      S_DIST_WAIT,
      S_DIST_NEXT,
      S_MUL_WAIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // next state and operation
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op       = OP_LOAD;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            if (stat.bad) begin
               state_in = S_DONE;
            end else begin
               op       = OP_TAN_INIT;
               state_in = S_TERM;
            end
         end
         S_TERM: begin
            if (stat.k_zero) begin
               state_in = S_FINAL;
            end else if (stat.f_ge_base) begin
               op       = OP_TAN_SAT;
               state_in = S_TAN_DONE;
            end else begin
               op       = OP_TERM_DIV;
               state_in = S_TERM_WAIT;
            end
         end
         S_TERM_WAIT: begin
            if (stat.div_done) begin
               op       = OP_TERM_END;
               state_in = S_TERM;
            end
         end
         S_FINAL: begin
            if (stat.f_ge_one) begin
               op = OP_TAN_SAT;
               state_in = S_TAN_DONE;
            end else begin
               op       = OP_FINAL_DIV;
               state_in = S_FINAL_WAIT;
            end
         end
         S_FINAL_WAIT: begin
            if (stat.div_done) begin
               op       = OP_FINAL_END;
               state_in = S_TAN_DONE;
            end
         end
         S_TAN_DONE: begin
            if (stat.beta_sel) begin
               op       = OP_MUL_START;
               state_in = S_MUL_WAIT;
            end else if (stat.t_zero) begin
               op       = OP_DIST_SAT;
               state_in = S_DIST_NEXT;
            end else begin
               op       = OP_DIST_DIV;
               state_in = S_DIST_WAIT;
            end
         end
         S_DIST_WAIT: begin
            if (stat.div_done) begin
               op       = OP_DIST_END;
               state_in = S_DIST_NEXT;
            end
         end
         S_DIST_NEXT: begin
            if (stat.want_h) begin
               op       = OP_SEL_BETA;
               state_in = S_INIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL_WAIT: begin
            if (stat.mul_done) begin
               op       = OP_HEIGHT_END;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign ready = ready_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == S_IDLE)
      else $error("ready outside idle");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == S_TERM_WAIT || state_ff == S_FINAL_WAIT ||
                         state_ff == S_DIST_WAIT))
      else $error("divider finished outside a wait state");

   a_load_done: assert property (@(posedge clock) disable iff (reset)
      out_load |=> state_ff == S_IDLE)
      else $error("result load did not return to idle");

endmodule

@@ hdl/tangent_range_height_finder.sv @@
// top level: csr registers, controller, datapath and result register
//
// Usage: an input beat on req_ carries angle_alpha and angle_beta (Q1.16
// radians). One result beat on rsp_ follows per input beat, carrying the
// distance, object height, height valid flag and range status.
// instrument_height (address 0) and fraction_depth (address 4) are written
// over the csr port; the user must write them only while the block is idle;
// the block itself does not enforce this. Each tangent takes up to depth+1
// serial divisions; the distance adds one division and the height a
// shift-add multiply. An out of range angle skips these steps. The shared
// radix-2 divider does every division, and one item is worked on at a time.
// Reset returns the registers to 1.5 m and depth 14 and empties the block.
// While the receiver stalls, a finished result waits in the output register
// and the next item is accepted and computed; it is held until the slot frees.
`timescale 1ns / 1ps

module tangent_range_height_finder
   import trhf_pkg::*;
#(
   parameter int MAX_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: angle_alpha[16:0], angle_beta[33:17], zero pad
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,
   // rsp_tdata: distance[47:0], object_height[95:48], height_valid[96],
   // status[97], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [HEIGHT_W-1:0] h_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic                rsp_valid_ff;
   logic [97:0]         rsp_data_ff;
   logic                req_fire, out_free, out_load, cfg_wr;
   trhf_op_type         op;
   trhf_stat_type       stat;
   logic [OUT_W-1:0]    distance, object_height;
   logic                height_valid, status;

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= HEIGHT_W'(98304);
         depth_ff <= DEPTH_W'(14);
      end else if (cfg_wr) begin
         unique case (csr_paddr[2])
            REG_INSTR_HEIGHT: h_ff     <= csr_pwdata[HEIGHT_W-1:0];
            REG_FRAC_DEPTH:   depth_ff <= csr_pwdata[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_paddr[2])
         REG_INSTR_HEIGHT: csr_prdata = 32'(h_ff);
         REG_FRAC_DEPTH:   csr_prdata = 32'(depth_ff);
         default:          csr_prdata = '0;
      endcase
   end

   trhf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .stat     (stat),
      .op       (op),
      .ready    (req_tready),
      .out_load (out_load)
   );

   trhf_dp #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .alpha_in      (req_tdata[16:0]),
      .beta_in       (req_tdata[33:17]),
      .h             (h_ff),
      .depth         (depth_ff),
      .stat          (stat),
      .distance      (distance),
      .object_height (object_height),
      .height_valid  (height_valid),
      .status        (status)
   );

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= {status, height_valid, object_height, distance};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result loaded over a waiting beat");

   a_status_clear: assert property (@(posedge clock) disable iff (reset)
      out_load && status |-> distance == '0 && !height_valid)
      else $error("out of range result carries data");

   a_hval_beta: assert property (@(posedge clock) disable iff (reset)
      out_load && height_valid |-> stat.want_h)
      else $error("height valid without beta");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the tangent range and height finder
`timescale 1ns / 1ps

module tb;
   import trhf_pkg::*;

   typedef struct {
      logic [OUT_W-1:0] distance;
      logic [OUT_W-1:0] object_height;
      logic             height_valid;
      logic             status;
   } range_result_type;

   typedef struct {
      logic [ANGLE_W-1:0] alpha;
      logic [ANGLE_W-1:0] beta;
      bit                 typed;
      range_result_type   result;
   } angle_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // angle_alpha[16:0], angle_beta[33:17], zero pad
   logic [39:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // distance[47:0], object_height[95:48], height_valid[96], status[97], zero pad
   logic [103:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // local copy of the registers
   logic [HEIGHT_W-1:0] height_reg = 23'd98304;
   logic [DEPTH_W-1:0]  depth_reg = 5'd14;

   range_result_type expected_ranges[$];
   int  fail_count = 0;
   int  results_seen = 0;
   bit  no_idle = 1'b0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   tangent_range_height_finder dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #80ms;
      $display("Some tests failed");
      $finish;
   end

   // lambert continued fraction tangent, Q.32
   function automatic logic [63:0] tangent_q32(logic [63:0] a, int depth);
      logic [63:0] x2, f, base, t;
      x2 = a * a;
      f = Q30_ONE;
      for (int k = depth; k >= 1; k--) begin
         base = 64'(2 * k + 1) << 30;
         if (f >= base) return 64'(TAN_SAT);
         f = (x2 << 28) / (base - f);
      end
      if (f >= Q30_ONE) return 64'(TAN_SAT);
      t = (a << 46) / (Q30_ONE - f);
      return (t > 64'(TAN_SAT)) ? 64'(TAN_SAT) : t;
   endfunction

   function automatic range_result_type range_from_angles(logic [ANGLE_W-1:0] alpha,
                                                          logic [ANGLE_W-1:0] beta);
      range_result_type r;
      int depth;
      logic [63:0]  ta, tb_tan, range_q, h;
      logic [127:0] prod;
      r = '{default: '0};
      h = 64'(height_reg);
      if (alpha == 0 || alpha > ANGLE_MAX || (beta != 0 && beta > ANGLE_MAX)) begin
         r.status = 1'b1;
         return r;
      end
      depth = int'(depth_reg);
      if (depth == 0) depth = 1;
      if (depth > 16) depth = 16;
      ta = tangent_q32(64'(alpha), depth);
      if (ta == 0) range_q = 64'(OUT_MAX);
      else begin
         range_q = (h << 32) / ta;
         if (range_q > 64'(OUT_MAX)) range_q = 64'(OUT_MAX);
      end
      r.distance = range_q[OUT_W-1:0];
      if (beta != 0) begin
         tb_tan = tangent_q32(64'(beta), depth);
         prod = (128'(range_q) * 128'(tb_tan)) >> 32;
         if (prod > 128'(OUT_MAX)) prod = 128'(OUT_MAX);
         prod = prod + 128'(h);
         if (prod > 128'(OUT_MAX)) prod = 128'(OUT_MAX);
         r.object_height = prod[OUT_W-1:0];
         r.height_valid = 1'b1;
      end
      return r;
   endfunction

   // register write: setup then access
   task automatic csr_write(logic index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_INSTR_HEIGHT) height_reg = value[HEIGHT_W-1:0];
      else depth_reg = value[DEPTH_W-1:0];
   endtask

   // offer one beat, record the expectation once it is taken
   task automatic send_angles(logic [ANGLE_W-1:0] alpha, logic [ANGLE_W-1:0] beta,
                              bit typed, range_result_type typed_result);
      if (!no_idle && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, beta, alpha};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_ranges.push_back(typed ? typed_result : range_from_angles(alpha, beta));
   endtask

   function automatic logic [ANGLE_W-1:0] random_angle();
      case ($urandom_range(9))
         0: return ANGLE_W'($urandom_range(131071));
         1: return ANGLE_W'($urandom_range(64, 1));
         2: return ANGLE_W'($urandom_range(91750, 88000));
         default: return ANGLE_W'($urandom_range(91750, 1));
      endcase
   endfunction

   // result side: random stalls, one long hold-off, field checks
   always @(posedge clock) begin
      range_result_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (expected_ranges.size() == 0) begin
               $error("unexpected result beat");
               fail_count = fail_count + 1;
            end else begin
               exp_r = expected_ranges.pop_front();
               if (rsp_tdata[47:0] !== exp_r.distance) begin
                  $error("distance: expected %0d, actual %0d", exp_r.distance,
                         rsp_tdata[47:0]);
                  fail_count = fail_count + 1;
               end
               if (rsp_tdata[95:48] !== exp_r.object_height) begin
                  $error("object_height: expected %0d, actual %0d",
                         exp_r.object_height, rsp_tdata[95:48]);
                  fail_count = fail_count + 1;
               end
               if (rsp_tdata[96] !== exp_r.height_valid) begin
                  $error("height_valid: expected %0d, actual %0d",
                         exp_r.height_valid, rsp_tdata[96]);
                  fail_count = fail_count + 1;
               end
               if (rsp_tdata[97] !== exp_r.status) begin
                  $error("status: expected %0d, actual %0d", exp_r.status,
                         rsp_tdata[97]);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (!hold_done && results_seen == 40) begin
            hold_done <= 1'b1;
            hold_left <= 12000;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= (hold_left == 1);
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 16);
         end
      end
   end

   // stimulus
   initial begin
      angle_row_type rows[$];
      range_result_type bad;
      logic [HEIGHT_W-1:0] phase_height[5];
      logic [DEPTH_W-1:0]  phase_depth[5];
      logic [ANGLE_W-1:0]  alpha, beta;

      bad = '{distance: '0, object_height: '0, height_valid: 1'b0, status: 1'b1};
      rows = '{
         '{17'd1, 17'd0, 1'b0, bad},
         '{17'd1, 17'd1, 1'b0, bad},
         '{17'd91750, 17'd0, 1'b0, bad},
         '{17'd91750, 17'd91750, 1'b0, bad},
         '{17'd1, 17'd91750, 1'b0, bad},
         '{17'd91750, 17'd1, 1'b0, bad},
         '{17'd65536, 17'd32768, 1'b0, bad},
         '{17'd51472, 17'd0, 1'b0, bad},
         '{17'd0, 17'd0, 1'b1, bad},
         '{17'd0, 17'd5000, 1'b1, bad},
         '{17'd91751, 17'd0, 1'b1, bad},
         '{17'd131071, 17'd131071, 1'b1, bad},
         '{17'd100, 17'd91751, 1'b1, bad},
         '{17'd30000, 17'd131071, 1'b1, bad}
      };
      phase_height = '{23'd1, 23'd6553600, 23'd8388607, 23'd0, 23'd98304};
      phase_depth  = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd7};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset settings
      foreach (rows[i]) send_angles(rows[i].alpha, rows[i].beta, rows[i].typed,
                                    rows[i].result);
      req_tvalid <= 1'b0;
      wait (expected_ranges.size() == 0);

      // random phases over several register settings
      for (int p = 0; p < 5; p++) begin
         csr_write(REG_INSTR_HEIGHT, 32'(phase_height[p]));
         csr_write(REG_FRAC_DEPTH, 32'(phase_depth[p]));
         if (p == 4) begin
            csr_write(REG_INSTR_HEIGHT, 32'($urandom_range(6553600, 1)));
            csr_write(REG_FRAC_DEPTH, 32'($urandom_range(16, 1)));
         end
         no_idle = (p == 2);
         for (int n = 0; n < 138; n++) begin
            alpha = random_angle();
            beta = ($urandom_range(3) == 0) ? 17'd0 : random_angle();
            send_angles(alpha, beta, 1'b0, bad);
         end
         req_tvalid <= 1'b0;
         wait (expected_ranges.size() == 0);
         @(posedge clock);
      end

      no_idle = 1'b0;
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_ranges.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
